[src/two_wire_bus_master_bit_engine_top_assert.svh]
// Assertion macros shared by the two-wire bus master RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef TWO_WIRE_BUS_MASTER_BIT_ENGINE_TOP_ASSERT_SVH
`define TWO_WIRE_BUS_MASTER_BIT_ENGINE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Clocked check that is switched off while reset is high.
`define TWBM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define TWBM_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TWBM_ASSERT(label, clk, rst, prop, msg)
`define TWBM_ASSERT_NR(label, clk, prop, msg)

`endif

`endif

[src/twbm_pkg.sv]
// Types and constants of the two-wire bus master bit engine.
// No dependencies; used by the channel interfaces and the top level.
package twbm_pkg;

   // Bits sent or received per byte command.
   localparam int BITS_PER_BYTE = 8;
   // Width of the data byte fields.
   localparam int BYTE_WIDTH = 8;

   // Commands carried in a request.
   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2,
      ACT_STOP  = 2'd3
   } action_type;

   // Sequencer operation; a command maps to its action plus one.
   typedef enum logic [2:0] {
      OP_IDLE  = 3'd0,
      OP_START = 3'd1,
      OP_WRITE = 3'd2,
      OP_READ  = 3'd3,
      OP_STOP  = 3'd4,
      OP_ACK   = 3'd5
   } op_type;

   // Result of one tick.
   typedef struct packed {
      logic                  scl_level;
      logic                  sda_level;
      logic                  sda_drive;
      logic                  busy_res;
      logic                  done_res;
      logic                  ack_bit;
      logic [BYTE_WIDTH-1:0] read_data;
   } rsp_type;

endpackage

[src/twbm_req_if.sv]
// Request channel of the two-wire bus master: one request per timing tick.
// Depends on twbm_pkg.
interface twbm_req_if
   import twbm_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic                  cmd_valid;
   logic [1:0]            action;
   logic [BYTE_WIDTH-1:0] write_data;
   logic                  sda_in;

   modport source (output valid, cmd_valid, action, write_data, sda_in, input ready);
   modport sink   (input valid, cmd_valid, action, write_data, sda_in, output ready);
endinterface

[src/twbm_rsp_if.sv]
// Result channel of the two-wire bus master: line levels and status per tick.
// Depends on twbm_pkg.
interface twbm_rsp_if
   import twbm_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic                  scl_level;
   logic                  sda_level;
   logic                  sda_drive;
   logic                  busy_res;
   logic                  done_res;
   logic                  ack_bit;
   logic [BYTE_WIDTH-1:0] read_data;

   modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                   ack_bit, read_data, input ready);
   modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                   ack_bit, read_data, output ready);
endinterface

[src/two_wire_bus_master_bit_engine_top.sv]
// Two-wire bus master bit engine: each accepted request loads its result into
// the output register; one request per cycle unless the result channel stalls.
// A request is taken while the previous result waits if that result leaves
// in the same cycle. Synchronous active-high reset: sequencer idle, clock low,
// data released, acknowledge held at one, read byte zero, no result pending.
// Depends on twbm_pkg, twbm_req_if, twbm_rsp_if and the assertion header.
`include "two_wire_bus_master_bit_engine_top_assert.svh"

module two_wire_bus_master_bit_engine_top
   import twbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   twbm_req_if.sink    req_bus,
   twbm_rsp_if.source  rsp_bus
);

   // Sequencer state.
   op_type                op_ff, op_in;
   logic [1:0]            phase_ff, phase_in;
   logic [3:0]            bit_ff, bit_in;
   logic [BYTE_WIDTH-1:0] shift_ff, shift_in;
   logic                  ack_ff, ack_in;
   logic [BYTE_WIDTH-1:0] rdh_ff, rdh_in;
   logic                  clk_line_ff, clk_line_in;
   logic                  dat_line_ff, dat_line_in;
   logic                  drv_ff, drv_in;

   // Result register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic req_fire;
   logic last_bit;
   logic busy;
   logic done;
   logic clock_after;

   // A request is taken when the result register is free or emptying.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // State registers advance once per accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff       <= OP_IDLE;
         phase_ff    <= 2'd0;
         bit_ff      <= 4'd0;
         shift_ff    <= '0;
         ack_ff      <= 1'b1;
         rdh_ff      <= '0;
         clk_line_ff <= 1'b0;
         dat_line_ff <= 1'b1;
         drv_ff      <= 1'b0;
      end else if (req_fire) begin
         op_ff       <= op_in;
         phase_ff    <= phase_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         ack_ff      <= ack_in;
         rdh_ff      <= rdh_in;
         clk_line_ff <= clk_line_in;
         dat_line_ff <= dat_line_in;
         drv_ff      <= drv_in;
      end
   end

   // Next state and tick result: launch a command when idle, then run one phase.
   always_comb begin
      op_in       = op_ff;
      phase_in    = phase_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      ack_in      = ack_ff;
      rdh_in      = rdh_ff;
      clk_line_in = clk_line_ff;
      dat_line_in = dat_line_ff;
      drv_in      = drv_ff;
      busy        = 1'b0;
      done        = 1'b0;
      clock_after = 1'b0;

      if (op_ff == OP_IDLE && req_bus.cmd_valid) begin
         op_in    = op_type'({1'b0, req_bus.action} + 3'd1);
         phase_in = 2'd0;
         bit_in   = 4'd0;
         shift_in = (req_bus.action == ACT_WRITE) ? req_bus.write_data : '0;
      end

      busy     = (op_in != OP_IDLE);
      last_bit = ({1'b0, bit_in} + 5'd1) >= 5'(BITS_PER_BYTE);

      case (op_in)
         OP_START: begin
            drv_in = 1'b1;
            if (phase_in == 2'd0) begin
               clk_line_in = 1'b0;
               dat_line_in = 1'b1;
               phase_in    = 2'd1;
            end else if (phase_in == 2'd1) begin
               clk_line_in = 1'b1;
               phase_in    = 2'd2;
            end else begin
               dat_line_in = 1'b0;
               done        = 1'b1;
               clock_after = 1'b1;
            end
         end
         OP_WRITE: begin
            drv_in = 1'b1;
            case (phase_in)
               2'd0: begin
                  clk_line_in = 1'b0;
                  phase_in    = 2'd1;
               end
               2'd1: begin
                  dat_line_in = shift_in[0];
                  phase_in    = 2'd2;
               end
               2'd2: begin
                  clk_line_in = 1'b1;
                  phase_in    = 2'd3;
               end
               default: begin
                  clk_line_in = 1'b1;
                  shift_in    = shift_in >> 1;
                  phase_in    = 2'd0;
                  if (last_bit) begin
                     bit_in = 4'd0;
                     op_in  = OP_ACK;
                  end else begin
                     bit_in = bit_in + 4'd1;
                  end
               end
            endcase
         end
         OP_ACK: begin
            dat_line_in = 1'b1;
            drv_in      = 1'b0;
            clk_line_in = 1'b1;
            if (phase_in == 2'd0) begin
               ack_in   = req_bus.sda_in;
               phase_in = 2'd1;
            end else begin
               done        = 1'b1;
               clock_after = 1'b1;
            end
         end
         OP_READ: begin
            drv_in = 1'b0;
            if (phase_in == 2'd0) begin
               clk_line_in = 1'b1;
               // Bits past the byte width are dropped.
               if (bit_in < 4'(BYTE_WIDTH) && req_bus.sda_in) begin
                  shift_in[bit_in[2:0]] = 1'b1;
               end
               phase_in = 2'd1;
            end else if (phase_in == 2'd1) begin
               clk_line_in = 1'b1;
               phase_in    = 2'd2;
            end else begin
               clk_line_in = 1'b0;
               phase_in    = 2'd0;
               if (last_bit) begin
                  rdh_in = shift_in;
                  done   = 1'b1;
               end else begin
                  bit_in = bit_in + 4'd1;
               end
            end
         end
         OP_STOP: begin
            drv_in = 1'b1;
            case (phase_in)
               2'd0: begin
                  dat_line_in = 1'b0;
                  clk_line_in = 1'b0;
                  phase_in    = 2'd1;
               end
               2'd1: begin
                  clk_line_in = 1'b1;
                  phase_in    = 2'd2;
               end
               2'd2: begin
                  dat_line_in = 1'b1;
                  phase_in    = 2'd3;
               end
               default: begin
                  clk_line_in = 1'b0;
                  done        = 1'b1;
               end
            endcase
         end
         default: begin
            op_in = OP_IDLE;
         end
      endcase

      // Result shows the lines as driven during this tick.
      rsp_in.scl_level = clk_line_in;
      rsp_in.sda_level = drv_in ? dat_line_in : 1'b1;
      rsp_in.sda_drive = drv_in;
      rsp_in.busy_res  = busy;
      rsp_in.done_res  = done;
      rsp_in.ack_bit   = ack_in;
      rsp_in.read_data = rdh_in;

      // Clock drops after the last tick of start and acknowledge.
      if (clock_after) begin
         clk_line_in = 1'b0;
      end
      if (done) begin
         op_in    = OP_IDLE;
         phase_in = 2'd0;
         bit_in   = 4'd0;
      end
   end

   // Output register valid flag.
   always_comb begin
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload loads with each accepted request.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.scl_level = rsp_ff.scl_level;
   assign rsp_bus.sda_level = rsp_ff.sda_level;
   assign rsp_bus.sda_drive = rsp_ff.sda_drive;
   assign rsp_bus.busy_res  = rsp_ff.busy_res;
   assign rsp_bus.done_res  = rsp_ff.done_res;
   assign rsp_bus.ack_bit   = rsp_ff.ack_bit;
   assign rsp_bus.read_data = rsp_ff.read_data;

   // Reset leaves the sequencer idle with no result pending.
   `TWBM_ASSERT_NR(a_reset_idle, clock,
      reset |=> (op_ff == OP_IDLE && !rsp_valid_ff), "reset did not idle the sequencer")

   // Between commands the clock line rests low.
   `TWBM_ASSERT(a_idle_clock_low, clock, reset,
      (op_ff == OP_IDLE) |-> !clk_line_ff, "clock line high while idle")

   // An idle tick without a command keeps the sequencer idle.
   `TWBM_ASSERT(a_idle_stays, clock, reset,
      (req_fire && op_ff == OP_IDLE && !req_bus.cmd_valid) |=> (op_ff == OP_IDLE),
      "sequencer left idle without a command")

   // The acknowledge slot releases data and holds the clock high.
   `TWBM_ASSERT(a_ack_slot, clock, reset,
      (req_fire && op_ff == OP_ACK) |=> (!rsp_ff.sda_drive && rsp_ff.scl_level),
      "acknowledge slot drove data or clock low")

   // Only write and stop use a fourth phase.
   `TWBM_ASSERT(a_phase_range, clock, reset,
      (op_ff != OP_WRITE && op_ff != OP_STOP) |-> (phase_ff != 2'd3),
      "phase out of range for operation")

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the two-wire bus master bit engine top level.
// Uses twbm_pkg, twbm_req_if and twbm_rsp_if; a tick predictor checks every result.
`timescale 1ns / 100ps

module testbench;
   import twbm_pkg::*;

   // One timing tick as offered on the request channel.
   typedef struct {
      logic                  cmd_valid;
      action_type            action;
      logic [BYTE_WIDTH-1:0] write_data;
      logic                  sda_in;
   } bus_tick_type;

   // How the data line answers during a command.
   localparam int SDA_RANDOM = 0;
   localparam int SDA_ONES   = 1;
   localparam int SDA_ZEROS  = 2;

   localparam int RANDOM_TICKS = 1750;
   localparam int IDLE_PCT     = 24;
   localparam int QUIET_FIRST  = 400;
   localparam int QUIET_LAST   = 900;
   localparam int HOLD_FIRST   = 1200;
   localparam int HOLD_LAST    = 1400;
   localparam int CYCLE_LIMIT  = 200000;

   logic clock = 1'b0;
   logic reset;

   twbm_req_if req_bus ();
   twbm_rsp_if rsp_bus ();

   two_wire_bus_master_bit_engine_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   bus_tick_type pending_ticks[$];
   rsp_type      expected_ticks[$];
   int           mismatch_count = 0;
   int           checked_count = 0;
   int           command_count[4] = '{0, 0, 0, 0};
   int           cycle_count = 0;
   int           rx_cycles = 0;

   // Predicted sequencer state.
   op_type                bus_op;
   logic [1:0]            phase;
   logic [3:0]            bit_pos;
   logic [BYTE_WIDTH-1:0] shift_reg;
   logic                  ack_sample;
   logic [BYTE_WIDTH-1:0] read_byte;
   logic                  clock_lvl;
   logic                  data_lvl;
   logic                  data_dir;

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Return the sequencer to its reset state.
   function void reset_bus_model();
      bus_op     = OP_IDLE;
      phase      = '0;
      bit_pos    = '0;
      shift_reg  = '0;
      ack_sample = 1'b1;
      read_byte  = '0;
      clock_lvl  = 1'b0;
      data_lvl   = 1'b1;
      data_dir   = 1'b0;
   endfunction

   // Advance the sequencer by one tick and return the line levels and status.
   function rsp_type predict_bus_tick(input bus_tick_type t);
      rsp_type r;
      logic    busy;
      logic    done;
      logic    clock_after;
      logic    last_bit;
      busy        = 1'b0;
      done        = 1'b0;
      clock_after = 1'b0;
      last_bit    = (int'(bit_pos) + 1) >= BITS_PER_BYTE;

      // A command is taken only while idle and starts on the same tick.
      if (bus_op == OP_IDLE && t.cmd_valid) begin
         bus_op    = op_type'({1'b0, t.action} + 3'd1);
         phase     = '0;
         bit_pos   = '0;
         shift_reg = (bus_op == OP_WRITE) ? t.write_data : '0;
         last_bit  = 1 >= BITS_PER_BYTE;
      end
      busy = (bus_op != OP_IDLE);

      case (bus_op)
         OP_START: begin
            data_dir = 1'b1;
            if (phase == 2'd0) begin
               clock_lvl = 1'b0;
               data_lvl  = 1'b1;
               phase     = 2'd1;
            end else if (phase == 2'd1) begin
               clock_lvl = 1'b1;
               phase     = 2'd2;
            end else begin
               data_lvl    = 1'b0;
               done        = 1'b1;
               clock_after = 1'b1;
            end
         end
         OP_WRITE: begin
            data_dir = 1'b1;
            if (phase == 2'd0) begin
               clock_lvl = 1'b0;
               phase     = 2'd1;
            end else if (phase == 2'd1) begin
               data_lvl = shift_reg[0];
               phase    = 2'd2;
            end else if (phase == 2'd2) begin
               clock_lvl = 1'b1;
               phase     = 2'd3;
            end else begin
               clock_lvl = 1'b1;
               shift_reg = shift_reg >> 1;
               phase     = 2'd0;
               if (last_bit) begin
                  bit_pos = '0;
                  bus_op  = OP_ACK;
               end else begin
                  bit_pos = bit_pos + 4'd1;
               end
            end
         end
         OP_ACK: begin
            data_lvl  = 1'b1;
            data_dir  = 1'b0;
            clock_lvl = 1'b1;
            if (phase == 2'd0) begin
               ack_sample = t.sda_in;
               phase      = 2'd1;
            end else begin
               done        = 1'b1;
               clock_after = 1'b1;
            end
         end
         OP_READ: begin
            data_dir = 1'b0;
            if (phase == 2'd0) begin
               clock_lvl = 1'b1;
               // Bits past the eighth are dropped.
               if (bit_pos < 4'd8 && t.sda_in) shift_reg[bit_pos[2:0]] = 1'b1;
               phase = 2'd1;
            end else if (phase == 2'd1) begin
               clock_lvl = 1'b1;
               phase     = 2'd2;
            end else begin
               clock_lvl = 1'b0;
               phase     = 2'd0;
               if (last_bit) begin
                  read_byte = shift_reg;
                  done      = 1'b1;
               end else begin
                  bit_pos = bit_pos + 4'd1;
               end
            end
         end
         OP_STOP: begin
            data_dir = 1'b1;
            if (phase == 2'd0) begin
               data_lvl  = 1'b0;
               clock_lvl = 1'b0;
               phase     = 2'd1;
            end else if (phase == 2'd1) begin
               clock_lvl = 1'b1;
               phase     = 2'd2;
            end else if (phase == 2'd2) begin
               data_lvl = 1'b1;
               phase    = 2'd3;
            end else begin
               clock_lvl = 1'b0;
               done      = 1'b1;
            end
         end
         default: bus_op = OP_IDLE;
      endcase

      r.scl_level = clock_lvl;
      r.sda_level = data_dir ? data_lvl : 1'b1;
      r.sda_drive = data_dir;
      r.busy_res  = busy;
      r.done_res  = done;
      r.ack_bit   = ack_sample;
      r.read_data = read_byte;

      if (clock_after) clock_lvl = 1'b0;
      if (done) begin
         bus_op  = OP_IDLE;
         phase   = '0;
         bit_pos = '0;
      end
      return r;
   endfunction

   // Compare one result field and log a mismatch.
   function void check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Bytes lean toward the all-zero and all-one extremes.
   function logic [7:0] pick_byte();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hff;
      return 8'($urandom);
   endfunction

   function int pick_sda_mode();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 6) return SDA_ONES;
      if (pick == 7) return SDA_ZEROS;
      return SDA_RANDOM;
   endfunction

   // Queue every tick of one command; later ticks may carry ignored commands.
   task automatic queue_command(input action_type act, input logic [7:0] data,
                                input int sda_mode, input int noise_pct);
      int           ticks;
      bus_tick_type t;
      case (act)
         ACT_START: ticks = 3;
         ACT_WRITE: ticks = BITS_PER_BYTE * 4 + 2;
         ACT_READ:  ticks = BITS_PER_BYTE * 3;
         default:   ticks = 4;
      endcase
      for (int i = 0; i < ticks; i++) begin
         t.cmd_valid  = (i == 0) || ($urandom_range(0, 99) < noise_pct);
         t.action     = (i == 0) ? act : action_type'($urandom_range(0, 3));
         t.write_data = (i == 0) ? data : 8'($urandom);
         if (sda_mode == SDA_ONES) t.sda_in = 1'b1;
         else if (sda_mode == SDA_ZEROS) t.sda_in = 1'b0;
         else t.sda_in = 1'($urandom_range(0, 1));
         pending_ticks.push_back(t);
      end
      command_count[act]++;
   endtask

   // Queue ticks that carry no command.
   task automatic queue_idle(input int count);
      bus_tick_type t;
      repeat (count) begin
         t.cmd_valid  = 1'b0;
         t.action     = action_type'($urandom_range(0, 3));
         t.write_data = 8'($urandom);
         t.sda_in     = 1'($urandom_range(0, 1));
         pending_ticks.push_back(t);
      end
   endtask

   task automatic queue_gap();
      queue_idle(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3));
   endtask

   // Request driver: offers the queued ticks with random gaps.
   always @(posedge clock) begin : drive_requests
      logic hold;
      logic offer;
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.cmd_valid  <= 1'b0;
         req_bus.action     <= ACT_START;
         req_bus.write_data <= '0;
         req_bus.sda_in     <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_ticks.push_back(predict_bus_tick(pending_ticks.pop_front()));
         hold = req_bus.valid && !req_bus.ready;
         if (hold) offer = 1'b1;
         else offer = (pending_ticks.size() > 0) &&
                      ((cycle_count >= QUIET_FIRST && cycle_count < QUIET_LAST) ||
                       $urandom_range(0, 99) >= IDLE_PCT);
         req_bus.valid <= offer;
         if (offer && !hold) begin
            req_bus.cmd_valid  <= pending_ticks[0].cmd_valid;
            req_bus.action     <= pending_ticks[0].action;
            req_bus.write_data <= pending_ticks[0].write_data;
            req_bus.sda_in     <= pending_ticks[0].sda_in;
         end
      end
   end

   // Result receiver: random stalls, one long hold-off and a quiet stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_cycles     <= 0;
      end else begin
         rx_cycles <= rx_cycles + 1;
         if (rx_cycles >= HOLD_FIRST && rx_cycles < HOLD_LAST) rsp_bus.ready <= 1'b0;
         else if (rx_cycles >= QUIET_FIRST && rx_cycles < QUIET_LAST) rsp_bus.ready <= 1'b1;
         else rsp_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Result monitor: each accepted result against the oldest prediction.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_ticks.size() == 0) begin
            $display("%0t ns: result with no request waiting, expected none, actual scl %b sda %b",
                     $time, rsp_bus.scl_level, rsp_bus.sda_level);
            mismatch_count++;
         end else begin
            want = expected_ticks.pop_front();
            check_field("scl_level", 8'(want.scl_level), 8'(rsp_bus.scl_level));
            check_field("sda_level", 8'(want.sda_level), 8'(rsp_bus.sda_level));
            check_field("sda_drive", 8'(want.sda_drive), 8'(rsp_bus.sda_drive));
            check_field("busy_res", 8'(want.busy_res), 8'(rsp_bus.busy_res));
            check_field("done_res", 8'(want.done_res), 8'(rsp_bus.done_res));
            check_field("ack_bit", 8'(want.ack_bit), 8'(rsp_bus.ack_bit));
            check_field("read_data", want.read_data, rsp_bus.read_data);
            checked_count++;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("two_wire_bus_master_bit_engine_top regression: fail");
         $finish;
      end
   end

   // Stimulus, reset and end of run.
   initial begin : stimulus
      int target;
      int bytes;
      req_bus.valid      = 1'b0;
      req_bus.cmd_valid  = 1'b0;
      req_bus.action     = ACT_START;
      req_bus.write_data = '0;
      req_bus.sda_in     = 1'b0;
      rsp_bus.ready      = 1'b0;
      reset              = 1'b1;
      reset_bus_model();

      // Directed: an idle tick, a start hit by commands while busy, and a
      // read with no write before it while the data line stays high.
      queue_idle(1);
      queue_command(ACT_START, 8'hff, SDA_RANDOM, 100);
      queue_command(ACT_READ, 8'h00, SDA_ONES, 100);

      // Random: mostly whole transfers, some commands in arbitrary order.
      target = pending_ticks.size() + RANDOM_TICKS;
      while (pending_ticks.size() < target) begin
         if ($urandom_range(0, 9) < 8) begin
            queue_command(ACT_START, pick_byte(), SDA_RANDOM, 25);
            queue_gap();
            queue_command(ACT_WRITE, pick_byte(), pick_sda_mode(), 25);
            queue_gap();
            bytes = $urandom_range(1, 3);
            repeat (bytes) begin
               queue_command(($urandom_range(0, 1) == 0) ? ACT_WRITE : ACT_READ,
                             pick_byte(), pick_sda_mode(), 25);
               queue_gap();
            end
            queue_command(ACT_STOP, pick_byte(), SDA_RANDOM, 25);
         end else begin
            queue_command(action_type'($urandom_range(0, 3)), pick_byte(),
                          pick_sda_mode(), 25);
         end
         queue_gap();
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_ticks.size() != 0 || req_bus.valid) @(posedge clock);
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Covered %0d ticks with %0d start, %0d write, %0d read and %0d stop commands.",
               checked_count, command_count[ACT_START], command_count[ACT_WRITE],
               command_count[ACT_READ], command_count[ACT_STOP]);
      $display("Included commands while busy, a long receiver stall and %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("two_wire_bus_master_bit_engine_top regression: pass");
      end else begin
         $display("two_wire_bus_master_bit_engine_top regression: fail");
      end
      $finish;
   end

endmodule
